### design/tpq_pkg.sv
// Shared types and codes for the task priority queue.
// No dependencies; used by tpq_cell, task_priority_queue and the testbench.
`timescale 1ns / 1ps

package tpq_pkg;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

endpackage

### design/tpq_cell.sv
// One slot of the sorted task row: holds a priority and payload.
// Compares the incoming task against its own and shifts with its neighbors.
// Depends on tpq_pkg.
`timescale 1ns / 1ps

module tpq_cell #(
  parameter int PRIO_W = 8,
  parameter int PAY_W  = 32
) (
  input  logic              clk,
  input  tpq_pkg::cell_ctl_t ctl,
  input  logic              valid,
  input  logic [PRIO_W-1:0] new_prio,
  input  logic [PAY_W-1:0]  new_pay,
  input  logic              left_beaten,
  input  logic [PRIO_W-1:0] left_prio,
  input  logic [PAY_W-1:0]  left_pay,
  input  logic [PRIO_W-1:0] right_prio,
  input  logic [PAY_W-1:0]  right_pay,
  output logic              beaten,
  output logic [PRIO_W-1:0] prio,
  output logic [PAY_W-1:0]  pay
);

  logic [PRIO_W-1:0] prio_r, prio_nxt;
  logic [PAY_W-1:0]  pay_r, pay_nxt;

  assign beaten = !valid || (new_prio > prio_r);
  assign prio   = prio_r;
  assign pay    = pay_r;

  always_comb begin
    prio_nxt = prio_r;
    pay_nxt  = pay_r;
    if (ctl.push && beaten) begin
      if (left_beaten) begin
        prio_nxt = left_prio;
        pay_nxt  = left_pay;
      end else begin
        prio_nxt = new_prio;
        pay_nxt  = new_pay;
      end
    end else if (ctl.pop) begin
      prio_nxt = right_prio;
      pay_nxt  = right_pay;
    end
  end

  always_ff @(posedge clk) begin
    prio_r <= prio_nxt;
    pay_r  <= pay_nxt;
  end

endmodule

### design/task_priority_queue.sv
// Task priority queue top level: a row of tpq_cell slots kept sorted by
// priority, oldest first among equals. Depends on tpq_pkg and tpq_cell.
//
// One request per clock cycle: busy is always low, and each request gives one
// result on the out_ ports, marked by out_strobe, in the cycle after it is
// taken. The receiver cannot stall. Every slot compares the pushed task with
// its own in parallel and shifts by one place, so a push or pop updates all
// slots at once at any CAPACITY; the head slot always holds the next task to
// pop. No clearing pass follows reset.
`timescale 1ns / 1ps

module task_priority_queue #(
  parameter int CAPACITY      = 16,
  parameter int PRIORITY_BITS = 8,
  parameter int PAYLOAD_BITS  = 32,
  localparam int CNT_W        = $clog2(CAPACITY + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_mode,
  input  logic [PRIORITY_BITS-1:0] in_priority,
  input  logic [PAYLOAD_BITS-1:0]  in_payload,
  output logic                     out_strobe,
  output logic [1:0]               out_status,
  output logic [PRIORITY_BITS-1:0] out_priority,
  output logic [PAYLOAD_BITS-1:0]  out_payload,
  output logic [CNT_W-1:0]         out_occupancy
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             strobe_r;
  logic [1:0]       status_r, status_nxt;
  logic [PRIORITY_BITS-1:0] oprio_r, oprio_nxt;
  logic [PAYLOAD_BITS-1:0]  opay_r, opay_nxt;

  logic accept, full, empty;
  tpq_pkg::cell_ctl_t ctl;

  logic                     valid_w  [CAPACITY];
  logic                     beaten_w [CAPACITY];
  logic [PRIORITY_BITS-1:0] prio_w   [CAPACITY];
  logic [PAYLOAD_BITS-1:0]  pay_w    [CAPACITY];

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign empty    = (count_r == '0);
  assign ctl.push = accept && (in_mode == tpq_pkg::MODE_PUSH) && !full;
  assign ctl.pop  = accept && (in_mode == tpq_pkg::MODE_POP) && !empty;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     lb;
    logic [PRIORITY_BITS-1:0] lp, rp;
    logic [PAYLOAD_BITS-1:0]  ld, rd;

    assign valid_w[i] = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      assign lb = 1'b0;
      assign lp = '0;
      assign ld = '0;
    end else begin : g_body
      assign lb = beaten_w[i-1];
      assign lp = prio_w[i-1];
      assign ld = pay_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign rp = '0;
      assign rd = '0;
    end else begin : g_mid
      assign rp = prio_w[i+1];
      assign rd = pay_w[i+1];
    end

    tpq_cell #(
      .PRIO_W(PRIORITY_BITS),
      .PAY_W (PAYLOAD_BITS)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .valid      (valid_w[i]),
      .new_prio   (in_priority),
      .new_pay    (in_payload),
      .left_beaten(lb),
      .left_prio  (lp),
      .left_pay   (ld),
      .right_prio (rp),
      .right_pay  (rd),
      .beaten     (beaten_w[i]),
      .prio       (prio_w[i]),
      .pay        (pay_w[i])
    );
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = tpq_pkg::ST_OK;
    oprio_nxt  = '0;
    opay_nxt   = '0;
    if (accept) begin
      if (in_mode == tpq_pkg::MODE_PUSH) begin
        if (full) begin
          status_nxt = tpq_pkg::ST_OVERFLOW;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end else if (empty) begin
        status_nxt = tpq_pkg::ST_EMPTY;
      end else begin
        oprio_nxt = prio_w[0];
        opay_nxt  = pay_w[0];
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      strobe_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    oprio_r  <= oprio_nxt;
    opay_r   <= opay_nxt;
  end

  assign out_strobe    = strobe_r;
  assign out_status    = status_r;
  assign out_priority  = oprio_r;
  assign out_payload   = opay_r;
  assign out_occupancy = count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_mode == tpq_pkg::MODE_PUSH) && !full)
      |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("push did not grow occupancy");

  a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(2)) |-> (prio_w[0] >= prio_w[1]))
    else $error("head slot out of order");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == tpq_pkg::ST_EMPTY) |-> (out_occupancy == '0))
    else $error("empty status with tasks held");

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept))
    else $error("result without request");

endmodule

### verif/tb_task_priority_queue.sv
// Self-checking testbench for task_priority_queue: push/pop requests against an
// in-bench slot model with arrival ranks. Depends on tpq_pkg and the queue RTL.
`timescale 1ns / 1ps

module tb_task_priority_queue;

  localparam int CAPACITY      = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int PAYLOAD_BITS  = 32;
  localparam int CNT_W         = $clog2(CAPACITY + 1);
  localparam int RANDOM_REQUESTS = 1800;

  typedef struct {
    logic [1:0]               status;
    logic [PRIORITY_BITS-1:0] prio;
    logic [PAYLOAD_BITS-1:0]  payload;
    logic [CNT_W-1:0]         occupancy;
  } reply_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     in_mode = tpq_pkg::MODE_PUSH;
  logic [PRIORITY_BITS-1:0] in_priority = '0;
  logic [PAYLOAD_BITS-1:0]  in_payload = '0;
  logic                     out_strobe;
  logic [1:0]               out_status;
  logic [PRIORITY_BITS-1:0] out_priority;
  logic [PAYLOAD_BITS-1:0]  out_payload;
  logic [CNT_W-1:0]         out_occupancy;

  logic [PRIORITY_BITS-1:0] slot_prio [CAPACITY];
  logic [PAYLOAD_BITS-1:0]  slot_payload [CAPACITY];
  int                       slot_rank [CAPACITY];
  int                       held_tasks = 0;

  reply_t replies_due [$];
  int     error_count = 0;
  bit     gaps_enabled = 1'b1;

  task_priority_queue #(
    .CAPACITY(CAPACITY),
    .PRIORITY_BITS(PRIORITY_BITS),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_mode(in_mode),
    .in_priority(in_priority),
    .in_payload(in_payload),
    .out_strobe(out_strobe),
    .out_status(out_status),
    .out_priority(out_priority),
    .out_payload(out_payload),
    .out_occupancy(out_occupancy)
  );

  always #4 clk = ~clk;

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] %0s mismatch: got %0h expected %0h", $time, field, got, want);
    error_count++;
  endtask

  task automatic compute_reply(input logic mode, input logic [PRIORITY_BITS-1:0] prio,
                               input logic [PAYLOAD_BITS-1:0] payload, output reply_t r);
    int best;
    int gone;
    int last;
    r.status = tpq_pkg::ST_OK;
    r.prio = '0;
    r.payload = '0;
    if (mode == tpq_pkg::MODE_PUSH) begin
      if (held_tasks >= CAPACITY) begin
        r.status = tpq_pkg::ST_OVERFLOW;
      end else begin
        slot_prio[held_tasks] = prio;
        slot_payload[held_tasks] = payload;
        slot_rank[held_tasks] = held_tasks;
        held_tasks++;
      end
    end else if (held_tasks == 0) begin
      r.status = tpq_pkg::ST_EMPTY;
    end else begin
      best = 0;
      for (int i = 1; i < held_tasks; i++) begin
        if (slot_prio[i] > slot_prio[best] ||
            (slot_prio[i] == slot_prio[best] && slot_rank[i] < slot_rank[best])) begin
          best = i;
        end
      end
      r.prio = slot_prio[best];
      r.payload = slot_payload[best];
      gone = slot_rank[best];
      last = held_tasks - 1;
      slot_prio[best] = slot_prio[last];
      slot_payload[best] = slot_payload[last];
      slot_rank[best] = slot_rank[last];
      held_tasks = last;
      for (int i = 0; i < held_tasks; i++) begin
        if (slot_rank[i] > gone) slot_rank[i]--;
      end
    end
    r.occupancy = CNT_W'(held_tasks);
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!gaps_enabled || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic send_request(input logic mode, input logic [PRIORITY_BITS-1:0] prio,
                              input logic [PAYLOAD_BITS-1:0] payload);
    reply_t r;
    int gap;
    start <= 1'b1;
    in_mode <= mode;
    in_priority <= prio;
    in_payload <= payload;
    @(posedge clk);
    while (busy) @(posedge clk);
    compute_reply(mode, prio, payload, r);
    replies_due.push_back(r);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_replies_drained();
    start <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_strobe) begin
      if (replies_due.size() == 0) begin
        $display("[%0t] result with no request outstanding", $time);
        error_count++;
      end else begin
        want = replies_due.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", 64'(out_status), 64'(want.status));
        if (out_priority !== want.prio)
          report_mismatch("priority", 64'(out_priority), 64'(want.prio));
        if (out_payload !== want.payload)
          report_mismatch("payload", 64'(out_payload), 64'(want.payload));
        if (out_occupancy !== want.occupancy)
          report_mismatch("occupancy", 64'(out_occupancy), 64'(want.occupancy));
      end
    end
  end

  task automatic test_basic_order();
    send_request(tpq_pkg::MODE_POP, 8'hff, 32'hffff_ffff);
    send_request(tpq_pkg::MODE_PUSH, 8'h00, 32'h0000_0000);
    send_request(tpq_pkg::MODE_PUSH, 8'hff, 32'hffff_ffff);
    send_request(tpq_pkg::MODE_PUSH, 8'h07, 32'h0000_000a);
    send_request(tpq_pkg::MODE_PUSH, 8'h07, 32'h0000_000b);
    send_request(tpq_pkg::MODE_PUSH, 8'h07, 32'h0000_000c);
    send_request(tpq_pkg::MODE_PUSH, 8'hff, 32'h5555_aaaa);
    repeat (6) send_request(tpq_pkg::MODE_POP, 8'h00, 32'h0);
    send_request(tpq_pkg::MODE_POP, 8'h00, 32'h0);
  endtask

  task automatic test_overflow();
    gaps_enabled = 1'b0;
    for (int i = 0; i < CAPACITY; i++)
      send_request(tpq_pkg::MODE_PUSH, PRIORITY_BITS'(i % 3), PAYLOAD_BITS'(32'h100 + i));
    send_request(tpq_pkg::MODE_PUSH, 8'hff, 32'hdead_beef);
    send_request(tpq_pkg::MODE_PUSH, 8'h00, 32'h0bad_f00d);
    gaps_enabled = 1'b1;
    for (int i = 0; i < 4; i++) send_request(tpq_pkg::MODE_POP, 8'h00, 32'h0);
    wait_replies_drained();
  endtask

  task automatic test_random_traffic();
    int sent;
    int push_pct;
    int prio_style;
    int phase_len;
    int phase_idx;
    logic mode;
    logic [PRIORITY_BITS-1:0] prio;
    sent = 0;
    phase_idx = 0;
    while (sent < RANDOM_REQUESTS) begin
      case ($urandom_range(0, 3))
        0: push_pct = 85;
        1: push_pct = 15;
        2: push_pct = 50;
        default: push_pct = 62;
      endcase
      prio_style = $urandom_range(0, 2);
      phase_len = $urandom_range(20, 80);
      gaps_enabled = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < phase_len; i++) begin
        mode = ($urandom_range(0, 99) < push_pct) ? tpq_pkg::MODE_PUSH : tpq_pkg::MODE_POP;
        case (prio_style)
          0: prio = PRIORITY_BITS'($urandom);
          1: prio = PRIORITY_BITS'($urandom_range(0, 3));
          default: prio = $urandom_range(0, 1) ? '1 : '0;
        endcase
        send_request(mode, prio, PAYLOAD_BITS'($urandom));
        sent++;
      end
      if (phase_idx == 0 || $urandom_range(0, 4) == 0) wait_replies_drained();
      phase_idx++;
    end
    gaps_enabled = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_order();
    test_overflow();
    test_random_traffic();
    wait_replies_drained();
    repeat (5) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
